/* hw/rtl/byte_stream_transform_unit_macros.svh */
// assertion helpers shared by the rtl
`ifndef BYTE_STREAM_TRANSFORM_UNIT_MACROS_SVH
`define BYTE_STREAM_TRANSFORM_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BSTU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bstu check failed");

// next-cycle implication, checked outside reset
`define BSTU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bstu check failed");

`endif

/* hw/rtl/bstu_pkg.sv */
package bstu_pkg;

   // operating modes
   localparam logic [1:0] MODE_SLICE  = 2'd0;
   localparam logic [1:0] MODE_XOR    = 2'd1;
   localparam logic [1:0] MODE_HEX    = 2'd2;
   localparam logic [1:0] MODE_BASE64 = 2'd3;

   // register indexes
   localparam logic CSR_MODE       = 1'b0;
   localparam logic CSR_KEY_LENGTH = 1'b1;

   // input item kinds
   localparam logic FUNC_KEY  = 1'b0;
   localparam logic FUNC_DATA = 1'b1;

   // fault codes
   localparam logic [2:0] FAULT_OK       = 3'd0;
   localparam logic [2:0] FAULT_HEX      = 3'd1;
   localparam logic [2:0] FAULT_B64_LEN  = 3'd2;
   localparam logic [2:0] FAULT_PAD_POS  = 3'd3;
   localparam logic [2:0] FAULT_SYMBOL   = 3'd4;
   localparam logic [2:0] FAULT_PAD_BITS = 3'd5;

   localparam logic [7:0] PAD_CHAR = 8'h3d;

   // front to back queue
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_LW    = $clog2(Q_DEPTH + 1);

   // wide enough for any key depth and any key_length value
   localparam int LEN_W = 17;

   typedef struct packed {
      logic [1:0]  mode;
      logic [12:0] key_length;
   } cfg_type;

   // one queue entry: up to three result bytes from one input item
   typedef struct packed {
      logic [23:0] data;
      logic [1:0]  last_idx;
      logic        byte_valid;
      logic        done;
      logic [2:0]  fault;
   } entry_type;

   // {invalid, value}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
      return r;
   endfunction

   // {invalid, value} over the standard alphabet
   function automatic logic [6:0] b64_value(input logic [7:0] c);
      logic [6:0] r;
      r = 7'h40;
      if (c >= 8'h41 && c <= 8'h5a) r = {1'b0, 6'(c - 8'h41)};
      else if (c >= 8'h61 && c <= 8'h7a) r = {1'b0, 6'(c - 8'h47)};
      else if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 6'(c + 8'h04)};
      else if (c == 8'h2b) r = 7'd62;
      else if (c == 8'h2f) r = 7'd63;
      return r;
   endfunction

endpackage

/* hw/rtl/byte_stream_transform_unit.sv */
// byte stream transform unit: slice, repeating-key xor, hex decode, strict base64 decode
// input channel: an item transfers when push is high and full is low; func selects a key
//   store write (key_slot, in_byte) or a data byte, stream_end marks a stream's last byte
// result channel: the oldest result sits on the rsp_ ports while empty is low and
//   transfers when pop is high; one data byte gives at most one result, a closing
//   base64 group gives up to three, a fault gives one error result
// configuration: index 0 is mode, index 1 is key_length; ready is always high and
//   writes belong between streams while the unit is idle
// path: a result passes the staging register (front decode with the key store read),
//   then the queue write, then the output register
// throughput: one input per cycle while full is low; the back end sends one result per
//   cycle while the receiver pops, so a three-byte base64 group drains while the four
//   input bytes of the next group arrive; full only rises when the receiver stalls
// reset: mode slice, key_length one, all stream state and queues cleared; the key
//   store is not cleared and must be loaded before xor mode reads it
// receiver stall: the output register holds, the queue fills, then full rises
module byte_stream_transform_unit import bstu_pkg::*; #(
   parameter int KEY_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        push,
   output logic        full,
   input  logic        req_func,
   input  logic [7:0]  req_in_byte,
   input  logic [11:0] req_key_slot,
   input  logic        req_stream_end,
   // result channel
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_run_last,
   output logic        rsp_stream_done,
   output logic [2:0]  rsp_fault,
   // configuration write channel
   input  logic        valid,
   output logic        ready,
   input  logic        csr_index,
   input  logic [12:0] csr_data
);

`include "byte_stream_transform_unit_macros.svh"

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   // front to back queue
   logic            q_push;
   entry_type       q_entry;
   logic            q_pop;
   entry_type       q_head;
   logic            q_nonempty;
   logic [Q_LW-1:0] q_level;

   assign ready = 1'b1;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (valid && ready) begin
         unique case (csr_index)
            CSR_MODE:       cfg_in.mode       = csr_data[1:0];
            CSR_KEY_LENGTH: cfg_in.key_length = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode       <= MODE_SLICE;
         cfg_ff.key_length <= 13'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: decode, stream state, key store
   bstu_front #(
      .KEY_DEPTH(KEY_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_func      (req_func),
      .req_in_byte   (req_in_byte),
      .req_key_slot  (req_key_slot),
      .req_stream_end(req_stream_end),
      .cfg           (cfg_ff),
      .q_level       (q_level),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   // short queue that decouples the two halves
   bstu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .q_push    (q_push),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .q_head    (q_head),
      .q_nonempty(q_nonempty),
      .q_level   (q_level)
   );

   // back: split entries into single results behind the output register
   bstu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_head         (q_head),
      .q_nonempty     (q_nonempty),
      .q_pop          (q_pop),
      .empty          (empty),
      .pop            (pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_done(rsp_stream_done),
      .rsp_fault      (rsp_fault)
   );

   // the queue never overruns, given the credit check in the front
   `BSTU_ASSERT_NOW(a_queue_bound, clock, reset, q_push, q_level < Q_LW'(Q_DEPTH) || q_pop)

   // a key write never produces a queue entry
   `BSTU_ASSERT_NEXT(a_key_write_silent, clock, reset, push && !full && req_func == FUNC_KEY, !q_push)

   // an error result closes its item and its stream
   `BSTU_ASSERT_NOW(a_error_closes, clock, reset, !empty && !rsp_byte_valid, rsp_run_last && rsp_stream_done)

   // a data result carries no fault code and an error result always does
   `BSTU_ASSERT_NOW(a_fault_matches, clock, reset, !empty, (rsp_fault == FAULT_OK) == rsp_byte_valid)

endmodule

/* hw/rtl/bstu_ram.sv */
module bstu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/bstu_front.sv */
module bstu_front import bstu_pkg::*; #(
   parameter int KEY_DEPTH = 4096
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   output logic            full,
   input  logic            req_func,
   input  logic [7:0]      req_in_byte,
   input  logic [11:0]     req_key_slot,
   input  logic            req_stream_end,
   input  cfg_type         cfg,
   input  logic [Q_LW-1:0] q_level,
   output logic            q_push,
   output entry_type       q_entry
);

   localparam int AW = KEY_DEPTH > 1 ? $clog2(KEY_DEPTH) : 1;
   localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(KEY_DEPTH);

   logic            accept;
   logic [LEN_W-1:0] slot_l;
   logic            key_wr;

   // per-stream state
   logic [AW-1:0] pos_ff, pos_in;
   logic [23:0]   acc_ff, acc_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic [1:0]    pad_ff, pad_in;
   logic [3:0]    hn_ff, hn_in;
   logic          pend_ff, pend_in;
   logic          flt_ff, flt_in;

   // staging register while the key byte is read
   logic          s1_valid_ff, s1_valid_in;
   entry_type     s1_entry_ff, s1_entry_in;
   logic          s1_xor_ff, s1_xor_in;

   logic [AW-1:0]    rd_addr;
   logic [7:0]       key_byte;
   logic [LEN_W-1:0] len;
   logic [AW-1:0]    pos_eff;
   logic [4:0]       hv;
   logic [6:0]       bv;
   logic [Q_LW:0]    occupancy;

   assign occupancy = {1'b0, q_level} + (Q_LW + 1)'(s1_valid_ff);
   assign full      = occupancy >= (Q_LW + 1)'(Q_DEPTH);
   assign accept    = push && !full;

   assign slot_l = LEN_W'(req_key_slot);
   assign key_wr = accept && (req_func == FUNC_KEY) && (slot_l < DEPTH_L);

   // effective key length and position
   always_comb begin
      len = LEN_W'(cfg.key_length);
      if (len == '0) len = LEN_W'(1);
      if (len > DEPTH_L) len = DEPTH_L;
      pos_eff = (LEN_W'(pos_ff) >= len) ? '0 : pos_ff;
   end

   assign rd_addr = pos_eff;
   assign hv = hex_value(req_in_byte);
   assign bv = b64_value(req_in_byte);

   bstu_ram #(
      .WIDTH(8),
      .DEPTH(KEY_DEPTH)
   ) u_key_store (
      .clock  (clock),
      .wr_en  (key_wr),
      .wr_addr(slot_l[AW-1:0]),
      .wr_data(req_in_byte),
      .rd_en  (accept),
      .rd_addr(rd_addr),
      .rd_data(key_byte)
   );

   always_comb begin
      logic        emit;
      logic [2:0]  fcode;
      logic [23:0] acc_new;
      logic [1:0]  pad_new;

      pos_in      = pos_ff;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      pad_in      = pad_ff;
      hn_in       = hn_ff;
      pend_in     = pend_ff;
      flt_in      = flt_ff;
      s1_valid_in = 1'b0;
      s1_xor_in   = 1'b0;
      s1_entry_in = '0;
      emit        = 1'b0;
      fcode       = FAULT_OK;
      acc_new     = '0;
      pad_new     = '0;

      if (accept && req_func == FUNC_DATA) begin
         if (flt_ff) begin
            // dropping until the end of the faulted stream
            if (req_stream_end) begin
               pos_in  = '0;
               acc_in  = '0;
               cnt_in  = '0;
               pad_in  = '0;
               hn_in   = '0;
               pend_in = 1'b0;
               flt_in  = 1'b0;
            end
         end else begin
            unique case (cfg.mode)
               MODE_SLICE: begin
                  emit = 1'b1;
                  s1_entry_in.data = {req_in_byte, 16'h0000};
               end
               MODE_XOR: begin
                  emit = 1'b1;
                  s1_xor_in = 1'b1;
                  s1_entry_in.data = {req_in_byte, 16'h0000};
                  pos_in = (LEN_W'(pos_eff) + LEN_W'(1) >= len) ? '0 : pos_eff + AW'(1);
               end
               MODE_HEX: begin
                  if (hv[4]) begin
                     fcode = FAULT_HEX;
                  end else if (pend_ff) begin
                     emit = 1'b1;
                     s1_entry_in.data = {hn_ff, hv[3:0], 16'h0000};
                     pend_in = 1'b0;
                     hn_in = '0;
                  end else if (req_stream_end) begin
                     fcode = FAULT_HEX;
                  end else begin
                     hn_in = hv[3:0];
                     pend_in = 1'b1;
                  end
               end
               MODE_BASE64: begin
                  pad_new = pad_ff;
                  acc_new = {acc_ff[17:0], 6'd0};
                  if (req_stream_end && cnt_ff != 2'd3) begin
                     fcode = FAULT_B64_LEN;
                  end else if (req_in_byte == PAD_CHAR) begin
                     if (cnt_ff < 2'd2) fcode = FAULT_PAD_POS;
                     pad_new = pad_ff + 2'd1;
                  end else if (bv[6] || pad_ff != 2'd0) begin
                     fcode = FAULT_SYMBOL;
                  end else begin
                     acc_new = {acc_ff[17:0], bv[5:0]};
                  end
                  if (fcode == FAULT_OK) begin
                     acc_in = acc_new;
                     pad_in = pad_new;
                     if (cnt_ff != 2'd3) begin
                        cnt_in = cnt_ff + 2'd1;
                     end else if (pad_new != 2'd0 && !req_stream_end) begin
                        fcode = FAULT_PAD_POS;
                     end else if ((pad_new == 2'd2 && acc_new[15:0] != 16'h0000) ||
                                  (pad_new == 2'd1 && acc_new[7:0] != 8'h00)) begin
                        fcode = FAULT_PAD_BITS;
                     end else begin
                        emit = 1'b1;
                        s1_entry_in.data = acc_new;
                        s1_entry_in.last_idx = 2'd2 - pad_new;
                        acc_in = '0;
                        cnt_in = '0;
                        pad_in = '0;
                     end
                  end
               end
               default: ;
            endcase

            if (fcode != FAULT_OK) begin
               // one error result, then drop unless this was the last byte
               pos_in  = '0;
               acc_in  = '0;
               cnt_in  = '0;
               pad_in  = '0;
               hn_in   = '0;
               pend_in = 1'b0;
               flt_in  = !req_stream_end;
               s1_valid_in = 1'b1;
               s1_xor_in   = 1'b0;
               s1_entry_in = '0;
               s1_entry_in.done  = 1'b1;
               s1_entry_in.fault = fcode;
            end else if (emit) begin
               s1_valid_in = 1'b1;
               s1_entry_in.byte_valid = 1'b1;
               s1_entry_in.done = req_stream_end;
               if (req_stream_end) begin
                  pos_in  = '0;
                  acc_in  = '0;
                  cnt_in  = '0;
                  pad_in  = '0;
                  hn_in   = '0;
                  pend_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         acc_ff      <= '0;
         cnt_ff      <= '0;
         pad_ff      <= '0;
         hn_ff       <= '0;
         pend_ff     <= 1'b0;
         flt_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         acc_ff      <= acc_in;
         cnt_ff      <= cnt_in;
         pad_ff      <= pad_in;
         hn_ff       <= hn_in;
         pend_ff     <= pend_in;
         flt_ff      <= flt_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_entry_ff <= s1_entry_in;
      s1_xor_ff   <= s1_xor_in;
   end

   // key byte arrives from the store in the cycle after the read, alongside the staging register
   always_comb begin
      q_entry = s1_entry_ff;
      if (s1_xor_ff) q_entry.data[23:16] = s1_entry_ff.data[23:16] ^ key_byte;
   end

   assign q_push = s1_valid_ff;

endmodule

/* hw/rtl/bstu_queue.sv */
module bstu_queue import bstu_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_push,
   input  entry_type       q_entry,
   input  logic            q_pop,
   output entry_type       q_head,
   output logic            q_nonempty,
   output logic [Q_LW-1:0] q_level
);

   entry_type       mem_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_LW-1:0] level_ff, level_in;

   always_comb begin
      wr_ptr_in = q_push ? wr_ptr_ff + Q_AW'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + Q_AW'(1) : rd_ptr_ff;
      level_in  = level_ff + Q_LW'(q_push) - Q_LW'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) mem_ff[wr_ptr_ff] <= q_entry;
   end

   assign q_head     = mem_ff[rd_ptr_ff];
   assign q_nonempty = level_ff != '0;
   assign q_level    = level_ff;

endmodule

/* hw/rtl/bstu_back.sv */
module bstu_back import bstu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  entry_type  q_head,
   input  logic       q_nonempty,
   output logic       q_pop,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_stream_done,
   output logic [2:0] rsp_fault
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] sub_ff, sub_in;
   logic [7:0] byte_ff, byte_in;
   logic       bvalid_ff, last_ff, done_ff, last_in;
   logic [2:0] fault_ff;
   logic       load;

   assign load    = q_nonempty && (!rsp_valid_ff || pop);
   assign last_in = sub_ff == q_head.last_idx;
   assign q_pop   = load && last_in;

   always_comb begin
      case (sub_ff)
         2'd0:    byte_in = q_head.data[23:16];
         2'd1:    byte_in = q_head.data[15:8];
         default: byte_in = q_head.data[7:0];
      endcase
      sub_in = sub_ff;
      if (load) sub_in = last_in ? 2'd0 : sub_ff + 2'd1;
      rsp_valid_in = rsp_valid_ff;
      if (load) rsp_valid_in = 1'b1;
      else if (pop) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sub_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sub_ff       <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= byte_in;
         bvalid_ff <= q_head.byte_valid;
         last_ff   <= last_in;
         done_ff   <= q_head.done && last_in;
         fault_ff  <= q_head.fault;
      end
   end

   assign empty           = !rsp_valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_byte_valid  = bvalid_ff;
   assign rsp_run_last    = last_ff;
   assign rsp_stream_done = done_ff;
   assign rsp_fault       = fault_ff;

endmodule
